FILE: src/cca_pkg.sv
// Shared constants, payload types and divider handshake structs for the
// cluster correlation average block. No dependencies.
package cca_pkg;

  localparam int SPIN_W       = 5;
  localparam int DEG_W        = 3;
  localparam int COEF_W       = 24;
  localparam int NUM_COEF     = 5;
  localparam int MAX_DEGREE   = 4;
  localparam int MAX_CLUSTERS = 1024;
  localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);
  localparam int ACC_W        = 32;
  localparam int PROD_W       = 32;
  localparam int SUM_W        = 48;
  localparam int FRAC_W       = 16;
  localparam int QUEUE_DEPTH  = 2;

  // Role of a site within its cluster and set.
  typedef enum logic [1:0] {
    KIND_SITE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef logic [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic [SPIN_W-1:0]          spin;
    logic [DEG_W-1:0]           degree;
    coef_t [NUM_COEF-1:0]       coef;
    kind_e                      kind;
  } site_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/cca_if.sv
// Valid/ready channel interfaces for site words in and result words out.
// Depends on cca_pkg.
interface cca_site_if;
  import cca_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SPIN_W-1:0] spin;
  logic [DEG_W-1:0]         degree;
  logic signed [COEF_W-1:0] coef_pow0;
  logic signed [COEF_W-1:0] coef_pow1;
  logic signed [COEF_W-1:0] coef_pow2;
  logic signed [COEF_W-1:0] coef_pow3;
  logic signed [COEF_W-1:0] coef_pow4;
  logic                     last_site;
  logic                     last_cluster;

  modport source (
    output valid, spin, degree, coef_pow0, coef_pow1, coef_pow2, coef_pow3, coef_pow4,
    output last_site, last_cluster,
    input  ready
  );
  modport sink (
    input  valid, spin, degree, coef_pow0, coef_pow1, coef_pow2, coef_pow3, coef_pow4,
    input  last_site, last_cluster,
    output ready
  );
endinterface

interface cca_result_if;
  import cca_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] correlation;
  logic                    saturated;

  modport source (output valid, correlation, saturated, input ready);
  modport sink (input valid, correlation, saturated, output ready);
endinterface

FILE: src/cluster_correlation_average.sv
// Cluster correlation average. Each input word is one lattice site; its basis
// polynomial is evaluated at the spin in Q16.16 by Horner's rule and multiplied
// into the cluster product, and a closing site adds the product to the set sum.
// A site that closes both its cluster and the set yields one result word: the
// sum over the cluster count as Q16.16, with a flag for any saturation in the
// set. In the back end a site takes a load, one step per degree on the shared
// 32x32 multiplier, a product multiply and a product rounding, plus a close
// step when it closes a cluster; closing the set adds the bit-serial 48-bit
// divide. A two-entry queue in front keeps taking sites, until it is full, while
// the back end works, and the result register holds a finished word while the
// next set is already being processed.
module cluster_correlation_average (
  input  logic         clk_i,
  input  logic         rst_ni,
  cca_site_if.sink     site_i,
  cca_result_if.source result_o
);
  import cca_pkg::*;

  site_t    entry;
  logic     entry_valid;
  logic     entry_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  cca_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .site_i        (site_i),
    .entry_o       (entry),
    .entry_valid_o (entry_valid),
    .entry_pop_i   (entry_pop)
  );

  cca_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cca_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (entry),
    .entry_valid_i (entry_valid),
    .entry_pop_o   (entry_pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .result_o      (result_o)
  );

endmodule

FILE: src/cca_front.sv
// Front end: accepts site words, clamps the degree, tags the site's role and
// queues it for the back end. Depends on cca_pkg and cca_site_if.
module cca_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  cca_site_if.sink       site_i,
  output cca_pkg::site_t entry_o,
  output logic           entry_valid_o,
  input  logic           entry_pop_i
);
  import cca_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  site_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  site_t             incoming;
  logic              push, pop;

  always_comb begin
    incoming.spin    = site_i.spin;
    incoming.degree  = (site_i.degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
                                                            : site_i.degree;
    incoming.coef[0] = site_i.coef_pow0;
    incoming.coef[1] = site_i.coef_pow1;
    incoming.coef[2] = site_i.coef_pow2;
    incoming.coef[3] = site_i.coef_pow3;
    incoming.coef[4] = site_i.coef_pow4;
    // A last-cluster mark only counts on a site that also closes its cluster.
    if (!site_i.last_site) begin
      incoming.kind = KIND_SITE;
    end else if (site_i.last_cluster) begin
      incoming.kind = KIND_END;
    end else begin
      incoming.kind = KIND_CLOSE;
    end
  end

  assign site_i.ready  = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign entry_valid_o = (fill_q != '0);
  assign entry_o       = slot_q[rd_ptr_q];
  assign push          = site_i.valid && site_i.ready;
  assign pop           = entry_pop_i && entry_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

FILE: src/cca_div.sv
// Restoring divider, one quotient bit per cycle, for the cluster sum over
// the cluster count. Depends on cca_pkg.
module cca_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cca_pkg::div_req_t req_i,
  output cca_pkg::div_rsp_t rsp_o
);
  import cca_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic [CNT_W:0]    trial, diff;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    trial  = {rem_q, quo_q[SUM_W-1]};
    diff   = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      step_d = STEP_W'(SUM_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[CNT_W]) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: src/cca_back.sv
// Back end: Horner evaluation and cluster product on one shared multiplier,
// cluster sum and count, final averaging and the result register.
// Depends on cca_pkg and cca_result_if; talks to the divider cca_div through its ports.
module cca_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cca_pkg::site_t    entry_i,
  input  logic              entry_valid_i,
  output logic              entry_pop_o,
  output cca_pkg::div_req_t div_req_o,
  input  cca_pkg::div_rsp_t div_rsp_i,
  cca_result_if.source      result_o
);
  import cca_pkg::*;

  localparam int MUL_W = 2 * ACC_W;

  localparam logic [PROD_W-1:0]      Q_ONE   = PROD_W'(1) << FRAC_W;
  localparam logic signed [MUL_W-1:0] Q_HALF = MUL_W'(1) << (FRAC_W - 1);
  localparam logic [CNT_W-1:0]       CNT_MAX = CNT_W'(MAX_CLUSTERS);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_HORNER = 7'b0000010,
    ST_PMUL   = 7'b0000100,
    ST_PFIN   = 7'b0001000,
    ST_CLOSE  = 7'b0010000,
    ST_DLOAD  = 7'b0100000,
    ST_DWAIT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic             ovf;
    logic [ACC_W-1:0] val;
  } sat_t;

  function automatic logic [ACC_W-1:0] coef_at(site_t s, logic [DEG_W-1:0] idx);
    logic [ACC_W-1:0] r;
    r = '0;
    if (int'(idx) < NUM_COEF) begin
      r = ACC_W'($signed(s.coef[idx]));
    end
    return r;
  endfunction

  function automatic sat_t sat_acc(logic signed [MUL_W-1:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[ACC_W-1:0];
    if (v[MUL_W-1:ACC_W-1] != {(MUL_W-ACC_W+1){v[MUL_W-1]}}) begin
      r.ovf = 1'b1;
      r.val = v[MUL_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  state_e                    state_q, state_d;
  site_t                     cur_q, cur_d;
  logic [ACC_W-1:0]          acc_q, acc_d;
  logic [DEG_W-1:0]          k_q, k_d;
  logic signed [MUL_W-1:0]   mul_q, mul_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;
  logic                      neg_q, neg_d;
  logic                      res_valid_q, res_valid_d;
  logic [ACC_W-1:0]          res_corr_q, res_corr_d;
  logic                      res_sat_q, res_sat_d;

  logic signed [ACC_W-1:0]   mul_a, mul_b;
  logic signed [MUL_W-1:0]   mul_full;
  logic signed [MUL_W-1:0]   horner_sum;
  logic signed [MUL_W-1:0]   rounded;
  logic signed [MUL_W-1:0]   scaled;
  logic [SUM_W:0]            sum_ext;
  sat_t                      horner_sat, prod_sat;
  logic [SUM_W-1:0]          quo;
  logic                      quo_hi, quo_lo;

  // One multiplier serves both the Horner steps (acc times spin) and the
  // cluster product (acc times running product).
  assign mul_a    = $signed(acc_q);
  assign mul_b    = (state_q == ST_HORNER) ? ACC_W'($signed(cur_q.spin)) : $signed(prod_q);
  assign mul_full = mul_a * mul_b;

  assign horner_sum = mul_full + MUL_W'($signed(coef_at(cur_q, k_q - 1'b1)));
  assign horner_sat = sat_acc(horner_sum);
  assign rounded    = mul_q + Q_HALF;
  assign scaled     = rounded >>> FRAC_W;
  assign prod_sat   = sat_acc(scaled);
  assign sum_ext    = {sum_q[SUM_W-1], sum_q}
                    + {{(SUM_W+1-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  assign div_req_o.start    = (state_q == ST_DLOAD);
  assign div_req_o.dividend = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign div_req_o.divisor  = cnt_q;

  // Quotient magnitude beyond the positive or negative 32-bit limit.
  assign quo    = div_rsp_i.quotient;
  assign quo_hi = |quo[SUM_W-1:ACC_W-1];
  assign quo_lo = (|quo[SUM_W-1:ACC_W]) || (quo[ACC_W-1] && (|quo[ACC_W-2:0]));

  assign entry_pop_o = (state_q == ST_IDLE) && entry_valid_i;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    k_d         = k_q;
    mul_d       = mul_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    neg_d       = neg_q;
    res_valid_d = res_valid_q && !result_o.ready;
    res_corr_d  = res_corr_q;
    res_sat_d   = res_sat_q;

    unique case (state_q)
      ST_IDLE: begin
        if (entry_valid_i) begin
          cur_d   = entry_i;
          acc_d   = coef_at(entry_i, entry_i.degree);
          k_d     = entry_i.degree;
          state_d = (entry_i.degree == '0) ? ST_PMUL : ST_HORNER;
        end
      end
      ST_HORNER: begin
        acc_d = horner_sat.val;
        ovf_d = ovf_q | horner_sat.ovf;
        k_d   = k_q - 1'b1;
        if (k_q == DEG_W'(1)) begin
          state_d = ST_PMUL;
        end
      end
      ST_PMUL: begin
        mul_d   = mul_full;
        state_d = ST_PFIN;
      end
      ST_PFIN: begin
        prod_d  = prod_sat.val;
        ovf_d   = ovf_q | prod_sat.ovf;
        state_d = (cur_q.kind == KIND_SITE) ? ST_IDLE : ST_CLOSE;
      end
      ST_CLOSE: begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
          ovf_d = 1'b1;
          sum_d = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          sum_d = sum_ext[SUM_W-1:0];
        end
        if (cnt_q >= CNT_MAX) begin
          cnt_d = CNT_MAX;
          ovf_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
        prod_d  = Q_ONE;
        state_d = (cur_q.kind == KIND_END) ? ST_DLOAD : ST_IDLE;
      end
      ST_DLOAD: begin
        neg_d   = sum_q[SUM_W-1];
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!div_rsp_i.busy && (!res_valid_q || result_o.ready)) begin
          res_valid_d = 1'b1;
          if (!neg_q && quo_hi) begin
            res_corr_d = {1'b0, {(ACC_W-1){1'b1}}};
            res_sat_d  = 1'b1;
          end else if (neg_q && quo_lo) begin
            res_corr_d = {1'b1, {(ACC_W-1){1'b0}}};
            res_sat_d  = 1'b1;
          end else begin
            res_corr_d = neg_q ? (~quo[ACC_W-1:0] + 1'b1) : quo[ACC_W-1:0];
            res_sat_d  = ovf_q;
          end
          sum_d   = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      prod_q      <= Q_ONE;
      sum_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      neg_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      prod_q      <= prod_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      neg_q       <= neg_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    acc_q      <= acc_d;
    mul_q      <= mul_d;
    res_corr_q <= res_corr_d;
    res_sat_q  <= res_sat_d;
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.correlation = $signed(res_corr_q);
  assign result_o.saturated   = res_sat_q;

endmodule

FILE: src/cca_checker.sv
// Port-level checks for the cluster correlation average block, bound to the
// top level. Depends only on the top level's ports.
module cca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        site_valid_i,
  input logic        site_ready_i,
  input logic        site_last_site_i,
  input logic        site_last_cluster_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] res_correlation_i,
  input logic        res_saturated_i
);

  logic [2:0] pend_q;
  logic       set_in, res_out;

  // Count sets whose closing site went in but whose result word is not out yet.
  assign set_in  = site_valid_i && site_ready_i && site_last_site_i && site_last_cluster_i;
  assign res_out = res_valid_i && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (set_in && !res_out) begin
      pend_q <= pend_q + 1'b1;
    end else if (res_out && !set_in) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_result_has_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (pend_q != '0))
    else $error("result word offered without a closed set");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result word withdrawn before it was taken");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> ($stable(res_correlation_i) && $stable(res_saturated_i)))
    else $error("stalled result word changed");

endmodule

bind cluster_correlation_average cca_checker u_cca_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .site_valid_i        (site_i.valid),
  .site_ready_i        (site_i.ready),
  .site_last_site_i    (site_i.last_site),
  .site_last_cluster_i (site_i.last_cluster),
  .res_valid_i         (result_o.valid),
  .res_ready_i         (result_o.ready),
  .res_correlation_i   (result_o.correlation),
  .res_saturated_i     (result_o.saturated)
);
